### design/lfu_cr_pkg.sv
// ----------------------------------------------------------------------------
// lfu_cr_pkg
// Shared types and constants for the LFU cache replacement block.
// ----------------------------------------------------------------------------
package lfu_cr_pkg;

    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int CAP_BITS   = 5;

    localparam logic [CAP_BITS-1:0]          CAP_RESET  = 5'd16;
    localparam logic signed [VALUE_BITS-1:0] VALUE_MISS = '1;

    typedef enum logic
    {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } op_t;

    // One request beat
    typedef struct packed
    {
        logic                         operation;
        logic [KEY_BITS-1:0]          lookup_key;
        logic signed [VALUE_BITS-1:0] write_value;
    } req_t;

    // One response beat
    typedef struct packed
    {
        logic                         hit;
        logic signed [VALUE_BITS-1:0] read_value;
        logic                         evicted;
        logic [KEY_BITS-1:0]          evicted_key;
    } rsp_t;

endpackage

### design/lfu_cr_store.sv
// ----------------------------------------------------------------------------
// lfu_cr_store
// Entry record memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lfu_cr_store
    import lfu_cr_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 84
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    output logic [AW-1:0] rd_idx,
    output logic          rd_ok
);

    logic [DW-1:0] mem_reg [DEPTH];
    logic [DW-1:0] rd_data_reg;
    logic [AW-1:0] rd_idx_reg;
    logic          rd_ok_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
            rd_idx_reg  <= rd_addr;
        end
    end

    // Flag the beat of read data that follows each read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            rd_ok_reg <= rd_en;
        end
    end

    assign rd_data = rd_data_reg;
    assign rd_idx  = rd_idx_reg;
    assign rd_ok   = rd_ok_reg;

endmodule

### design/lfu_cr_scan.sv
// ----------------------------------------------------------------------------
// lfu_cr_scan
// Shared compare unit: key match, victim choice and free slot, one entry a cycle.
// ----------------------------------------------------------------------------
module lfu_cr_scan
    import lfu_cr_pkg::*;
#(
    parameter int AW = 4,
    parameter int CB = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  eval,
    input  logic [AW-1:0]         idx,
    input  logic                  ent_valid,
    input  logic [KEY_BITS-1:0]   ent_key,
    input  logic [VALUE_BITS-1:0] ent_value,
    input  logic [CB-1:0]         ent_count,
    input  logic [AW-1:0]         ent_rank,
    input  logic [KEY_BITS-1:0]   lookup_key,
    output logic                  found,
    output logic [AW-1:0]         found_idx,
    output logic [AW-1:0]         found_rank,
    output logic [VALUE_BITS-1:0] found_value,
    output logic                  vic_ok,
    output logic [AW-1:0]         vic_idx,
    output logic [AW-1:0]         vic_rank,
    output logic [KEY_BITS-1:0]   vic_key,
    output logic                  free_ok,
    output logic [AW-1:0]         free_idx
);

    logic                  found_reg;
    logic [AW-1:0]         found_idx_reg;
    logic [AW-1:0]         found_rank_reg;
    logic [VALUE_BITS-1:0] found_value_reg;
    logic                  vic_ok_reg;
    logic [AW-1:0]         vic_idx_reg;
    logic [AW-1:0]         vic_rank_reg;
    logic [CB-1:0]         vic_count_reg;
    logic [KEY_BITS-1:0]   vic_key_reg;
    logic                  free_ok_reg;
    logic [AW-1:0]         free_idx_reg;

    logic take_match;
    logic take_victim;
    logic take_free;

    assign take_match  = eval && ent_valid && (ent_key == lookup_key) && !found_reg;
    assign take_free   = eval && !ent_valid && !free_ok_reg;
    // Lowest count wins; on equal counts the older entry (higher rank) wins
    assign take_victim = eval && ent_valid &&
                         (!vic_ok_reg || (ent_count < vic_count_reg) ||
                          ((ent_count == vic_count_reg) && (ent_rank > vic_rank_reg)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg   <= 1'b0;
            vic_ok_reg  <= 1'b0;
            free_ok_reg <= 1'b0;
        end
        else if (start)
        begin
            found_reg   <= 1'b0;
            vic_ok_reg  <= 1'b0;
            free_ok_reg <= 1'b0;
        end
        else
        begin
            if (take_match)
            begin
                found_reg <= 1'b1;
            end
            if (take_victim)
            begin
                vic_ok_reg <= 1'b1;
            end
            if (take_free)
            begin
                free_ok_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_match)
        begin
            found_idx_reg   <= idx;
            found_rank_reg  <= ent_rank;
            found_value_reg <= ent_value;
        end
        if (take_victim)
        begin
            vic_idx_reg   <= idx;
            vic_rank_reg  <= ent_rank;
            vic_count_reg <= ent_count;
            vic_key_reg   <= ent_key;
        end
        if (take_free)
        begin
            free_idx_reg <= idx;
        end
    end

    assign found       = found_reg;
    assign found_idx   = found_idx_reg;
    assign found_rank  = found_rank_reg;
    assign found_value = found_value_reg;
    assign vic_ok      = vic_ok_reg;
    assign vic_idx     = vic_idx_reg;
    assign vic_rank    = vic_rank_reg;
    assign vic_key     = vic_key_reg;
    assign free_ok     = free_ok_reg;
    assign free_idx    = free_idx_reg;

endmodule

### design/lfu_cache_replacement.sv
// ----------------------------------------------------------------------------
// lfu_cache_replacement
// Key-value store with least-frequently-used eviction, oldest first on ties.
// ----------------------------------------------------------------------------
//
//  Channel  Signals                      Direction  Beat taken when
//  -------  ---------------------------  ---------  ----------------------
//  request  in_valid, in_stall, in_data  in         in_valid && !in_stall
//  response out_valid, out_stall, out_data  out     out_valid && !out_stall
//  config   cfg_wr_en, cfg_wr_data       in         cfg_wr_en
//
//  One request occupies the block (accept to next accept) for two passes
//  over the entry memory when it hits or inserts, and for one pass when it
//  changes nothing. The passes come from the single read port of the entry
//  memory: one pass reads every entry through the compare unit, a second pass
//  reads and rewrites every entry to age the recency ranks.
//  Reset (rst_n low) empties the store and sets capacity to 16; writing the
//  capacity register empties it as well. No clearing pass is needed: valid
//  bits live in flops.
//  A stalled response holds in the output register; the next request beat
//  is taken meanwhile, and its response waits in DONE until the register
//  frees up.
// ----------------------------------------------------------------------------
module lfu_cache_replacement
    import lfu_cr_pkg::*;
#(
    parameter int ENTRIES    = 16,
    parameter int COUNT_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  req_t                in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output rsp_t                out_data,
    input  logic                cfg_wr_en,
    input  logic [CAP_BITS-1:0] cfg_wr_data
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int OW = (CW > CAP_BITS) ? CW : CAP_BITS;
    localparam int DW = KEY_BITS + VALUE_BITS + COUNT_BITS + AW;

    localparam logic [CW-1:0]         ENT_CNT   = CW'(ENTRIES);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
    localparam logic [AW-1:0]         RANK_ONE  = AW'(1);

    typedef enum logic [4:0]
    {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_DECIDE = 5'b00100,
        ST_UPDATE = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    req_t                req_reg;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [ENTRIES-1:0]  valid_reg, valid_next;
    logic [CW-1:0]       occ_reg;
    logic [CAP_BITS-1:0] capacity_reg;
    logic                evict_reg;
    logic                out_valid_reg;
    rsp_t                out_data_reg;

    // Memory port
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [DW-1:0] wr_data;
    logic          rd_en;
    logic [DW-1:0] rd_data;
    logic [AW-1:0] rd_idx;
    logic          rd_ok;

    // Fields of the record coming out of the memory
    logic [KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0] rd_value;
    logic [COUNT_BITS-1:0] rd_count;
    logic [AW-1:0]         rd_rank;

    // Scan results
    logic                  found;
    logic [AW-1:0]         found_idx;
    logic [AW-1:0]         found_rank;
    logic [VALUE_BITS-1:0] found_value;
    logic                  vic_ok;
    logic [AW-1:0]         vic_idx;
    logic [AW-1:0]         vic_rank;
    logic [KEY_BITS-1:0]   vic_key;
    logic                  free_ok;
    logic [AW-1:0]         free_idx;

    // Decision
    logic          accept;
    logic          out_free;
    logic          cnt_lt;
    logic          is_put;
    logic          store_full;
    logic          do_insert;
    logic          do_evict;
    logic [AW-1:0] slot_idx;
    logic          entry_live;
    rsp_t          rsp;

    assign accept   = (state_reg == ST_IDLE) && in_valid;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign cnt_lt   = (cnt_reg < ENT_CNT);
    assign is_put   = (req_reg.operation == OP_PUT);

    assign {rd_key, rd_value, rd_count, rd_rank} = rd_data;

    // Full when occupancy reaches min(capacity, ENTRIES)
    assign store_full = (OW'(occ_reg) >= OW'(capacity_reg)) || (occ_reg == ENT_CNT);
    assign do_insert  = !found && is_put && (capacity_reg != '0);
    assign do_evict   = do_insert && store_full && vic_ok;

    // Insert into the lowest free index, counting the freshly evicted slot
    assign slot_idx = (do_evict && (!free_ok || (vic_idx < free_idx))) ? vic_idx : free_idx;

    // Run the memory through one pass during SCAN and one during UPDATE
    assign rd_en = ((state_reg == ST_SCAN) || (state_reg == ST_UPDATE)) && cnt_lt;

    lfu_cr_store #(
        .DEPTH (ENTRIES),
        .AW    (AW),
        .DW    (DW)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (cnt_reg[AW-1:0]),
        .rd_data (rd_data),
        .rd_idx  (rd_idx),
        .rd_ok   (rd_ok)
    );

    lfu_cr_scan #(
        .AW (AW),
        .CB (COUNT_BITS)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (accept),
        .eval        (rd_ok && (state_reg == ST_SCAN)),
        .idx         (rd_idx),
        .ent_valid   (valid_reg[rd_idx]),
        .ent_key     (rd_key),
        .ent_value   (rd_value),
        .ent_count   (rd_count),
        .ent_rank    (rd_rank),
        .lookup_key  (req_reg.lookup_key),
        .found       (found),
        .found_idx   (found_idx),
        .found_rank  (found_rank),
        .found_value (found_value),
        .vic_ok      (vic_ok),
        .vic_idx     (vic_idx),
        .vic_rank    (vic_rank),
        .vic_key     (vic_key),
        .free_ok     (free_ok),
        .free_idx    (free_idx)
    );

    // Write-back pass: rewrite the touched entry and age the ranks of the rest
    assign entry_live = valid_reg[rd_idx] && !(do_evict && (rd_idx == vic_idx));

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = rd_idx;
        wr_data = rd_data;
        if (rd_ok && (state_reg == ST_UPDATE))
        begin
            if (found)
            begin
                if (rd_idx == found_idx)
                begin
                    wr_en   = 1'b1;
                    wr_data = {rd_key,
                               is_put ? VALUE_BITS'(req_reg.write_value) : rd_value,
                               (rd_count == COUNT_MAX) ? rd_count : rd_count + COUNT_ONE,
                               AW'(0)};
                end
                else if (valid_reg[rd_idx] && (rd_rank < found_rank))
                begin
                    wr_en   = 1'b1;
                    wr_data = {rd_key, rd_value, rd_count, rd_rank + RANK_ONE};
                end
            end
            else if (rd_idx == slot_idx)
            begin
                wr_en   = 1'b1;
                wr_data = {req_reg.lookup_key, VALUE_BITS'(req_reg.write_value),
                           COUNT_ONE, AW'(0)};
            end
            else if (entry_live)
            begin
                // Older than the victim: drop one for the eviction, add one for the insert
                wr_en   = 1'b1;
                wr_data = {rd_key, rd_value, rd_count,
                           (do_evict && (rd_rank > vic_rank)) ? rd_rank : rd_rank + RANK_ONE};
            end
        end
    end

    // Valid bits: clear on a capacity write, retire the victim and claim the
    // slot at the end of the write-back pass
    always_comb
    begin
        valid_next = valid_reg;
        if (cfg_wr_en)
        begin
            valid_next = '0;
        end
        else if ((state_reg == ST_UPDATE) && !cnt_lt && do_insert)
        begin
            if (do_evict)
            begin
                valid_next[vic_idx] = 1'b0;
            end
            valid_next[slot_idx] = 1'b1;
        end
    end

    // Response built from the scan results; the eviction flag is the one
    // decided before occupancy moved
    always_comb
    begin
        rsp.hit         = found;
        rsp.read_value  = (found && !is_put) ? $signed(found_value) : VALUE_MISS;
        rsp.evicted     = evict_reg;
        rsp.evicted_key = evict_reg ? vic_key : '0;
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                    cnt_next   = '0;
                end
            end
            ST_SCAN:
            begin
                // Advance until the last read beat has gone through the compare unit
                if (cnt_lt)
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
                else
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                cnt_next   = '0;
                state_next = (found || do_insert) ? ST_UPDATE : ST_DONE;
            end
            ST_UPDATE:
            begin
                if (cnt_lt)
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Hold until the output register is free
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            valid_reg     <= '0;
            occ_reg       <= '0;
            capacity_reg  <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;

            if (cfg_wr_en)
            begin
                // Capacity write empties the store
                capacity_reg <= cfg_wr_data;
                occ_reg      <= '0;
            end
            else if ((state_reg == ST_UPDATE) && !cnt_lt && do_insert && !do_evict)
            begin
                occ_reg <= occ_reg + CW'(1);
            end

            if ((state_reg == ST_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= in_data;
        end
        if (state_reg == ST_DECIDE)
        begin
            evict_reg <= do_evict;
        end
        if ((state_reg == ST_DONE) && out_free)
        begin
            out_data_reg <= rsp;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
